// ----- src/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define CHK_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check, also checked during reset
`define CHK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/srlm_pkg.sv -----
// shared constants for the stereo rms level meter
// no dependencies
`default_nettype none

package srlm_pkg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'b1;

    localparam logic [15:0] GAIN_RESET = 16'd4588;
    localparam logic [15:0] FULL_SCALE_RESET = 16'd11141;

    localparam int unsigned IN_DATA_W = 32;
    localparam int unsigned OUT_DATA_W = 80;
    localparam int unsigned SMOOTH_W = 24;

    typedef struct packed {
        logic [31:0] buffer_count;
        logic [15:0] scaled_level;
        logic [15:0] smoothed_level;
        logic [15:0] rms_level;
    } t_result;

endpackage

`default_nettype wire

// ----- src/srlm_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module srlm_div #(
    parameter int unsigned DIVIDEND_W = 40,
    parameter int unsigned DIVISOR_W = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quotient
);

    localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- src/stereo_rms_level_meter_top.sv -----
// a frame counted into a buffer that does not close it passes ST_SQ_L, ST_SQ_R and ST_SQ_ACC before ready returns
// a closing frame then runs the mean-square division, the 16-step square root, the smoothing
// multiply and the full-scale division; both divisions use the bit-serial divider
// one frame in work at a time; a finished result waits in the output register
// synchronous active-low reset clears sums, counts, smoothing state and restores config
`default_nettype none
`include "assert_macros.svh"

module stereo_rms_level_meter_top
    import srlm_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = 256,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input beats
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // left_sample, right_sample
    input  wire logic                  i_s_axis_tlast,  // last_frame
    // result beats
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata   // rms, smoothed, scaled, buffer_count
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned SUM_W = 32 + $clog2(MAX_FRAMES);
    localparam int unsigned DIVS_W = (CNT_W + 1 > 16) ? CNT_W + 1 : 16;
    localparam int unsigned EXT_W = SAMPLE_BITS + 17;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SQ_L    = 4'd1;
    localparam logic [3:0] ST_SQ_R    = 4'd2;
    localparam logic [3:0] ST_SQ_ACC  = 4'd3;
    localparam logic [3:0] ST_MS_GO   = 4'd4;
    localparam logic [3:0] ST_MS_WAIT = 4'd5;
    localparam logic [3:0] ST_SQRT    = 4'd6;
    localparam logic [3:0] ST_SM_A    = 4'd7;
    localparam logic [3:0] ST_SM_B    = 4'd8;
    localparam logic [3:0] ST_SM_C    = 4'd9;
    localparam logic [3:0] ST_SC_GO   = 4'd10;
    localparam logic [3:0] ST_SC_WAIT = 4'd11;
    localparam logic [3:0] ST_DONE    = 4'd12;

    logic [3:0]          r_state;
    logic [15:0]         r_gain;
    logic [15:0]         r_full;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [SMOOTH_W-1:0] r_smooth;
    logic [31:0]         r_bufs;
    logic                r_last;
    logic [15:0]         r_lmag;
    logic [15:0]         r_rmag;
    logic [40:0]         r_prod;
    logic [40:0]         r_macc;
    logic [31:0]         r_x;
    logic [31:0]         r_res;
    logic [31:0]         r_bit;
    logic [15:0]         r_scaled;
    logic                r_out_valid;
    t_result             r_out;

    logic [15:0]         lmag;
    logic [15:0]         rmag;
    logic                accept;
    logic                out_free;
    logic [23:0]         mul_a;
    logic [16:0]         mul_b;
    logic [41:0]         sm_sum;
    logic [31:0]         rb_sum;
    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic [DIVS_W-1:0]   div_divisor;
    logic                div_done;
    logic [SUM_W-1:0]    div_quo;

    // magnitude of a sample read as SAMPLE_BITS wide, scaled to Q0.16
    function automatic logic [15:0] halved_mag(input logic [15:0] raw);
        logic [EXT_W-1:0]       ext;
        logic [SAMPLE_BITS-1:0] v;
        logic [SAMPLE_BITS:0]   m;
        logic [EXT_W-1:0]       w;
        ext = EXT_W'(raw);
        v   = ext[SAMPLE_BITS-1:0];
        m   = v[SAMPLE_BITS-1] ? ((SAMPLE_BITS+1)'(1) << SAMPLE_BITS) - {1'b0, v}
                               : {1'b0, v};
        w   = (EXT_W'(m) << 16) >> SAMPLE_BITS;
        return w[15:0];
    endfunction

    always_comb begin
        lmag = halved_mag(i_s_axis_tdata[15:0]);
        rmag = halved_mag(i_s_axis_tdata[31:16]);
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_SQ_L: begin
                mul_a = 24'(r_lmag);
                mul_b = 17'(r_lmag);
            end
            ST_SQ_R: begin
                mul_a = 24'(r_rmag);
                mul_b = 17'(r_rmag);
            end
            ST_SM_A: begin
                mul_a = r_smooth;
                mul_b = 17'h10000 - {1'b0, r_gain};
            end
            ST_SM_B: begin
                mul_a = {r_res[15:0], 8'b0};
                mul_b = {1'b0, r_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 41'(mul_a) * 41'(mul_b);
    end

    assign sm_sum = {1'b0, r_macc} + {1'b0, r_prod};
    assign rb_sum = r_res + r_bit;

    // divider operands
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_sum;
        div_divisor  = DIVS_W'({r_count, 1'b0});
        if (r_state == ST_MS_GO) begin
            div_start = (r_count != '0);
        end else if (r_state == ST_SC_GO) begin
            div_start    = (r_full != '0);
            div_dividend = SUM_W'({r_smooth, 8'b0});
            div_divisor  = DIVS_W'(r_full);
        end
    end

    srlm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (DIVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_full <= FULL_SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SMOOTHING_GAIN: r_gain <= i_cfg_data;
                CFG_FULL_SCALE:     r_full <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and accumulation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_smooth    <= '0;
            r_bufs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (r_count < MAX_CNT) begin
                            r_state <= ST_SQ_L;
                        end else if (i_s_axis_tlast) begin
                            r_state <= ST_MS_GO;
                        end
                    end
                end
                ST_SQ_L: r_state <= ST_SQ_R;
                ST_SQ_R: begin
                    r_sum   <= r_sum + SUM_W'(r_prod);
                    r_state <= ST_SQ_ACC;
                end
                ST_SQ_ACC: begin
                    r_sum   <= r_sum + SUM_W'(r_prod);
                    r_count <= r_count + 1'b1;
                    r_state <= r_last ? ST_MS_GO : ST_IDLE;
                end
                ST_MS_GO: begin
                    r_state <= (r_count != '0) ? ST_MS_WAIT : ST_SQRT;
                end
                ST_MS_WAIT: begin
                    if (div_done) begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_bit == '0) begin
                        r_state <= ST_SM_A;
                    end
                end
                ST_SM_A: r_state <= ST_SM_B;
                ST_SM_B: r_state <= ST_SM_C;
                ST_SM_C: begin
                    r_smooth <= sm_sum[SMOOTH_W+15:16];
                    r_state  <= ST_SC_GO;
                end
                ST_SC_GO: begin
                    r_state <= (r_full != '0) ? ST_SC_WAIT : ST_DONE;
                end
                ST_SC_WAIT: begin
                    if (div_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_bufs      <= r_bufs + 1'b1;
                        r_sum       <= '0;
                        r_count     <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lmag <= lmag;
            r_rmag <= rmag;
            r_last <= i_s_axis_tlast;
        end
        if (r_state == ST_SM_B) begin
            r_macc <= r_prod;
        end
        // square root, two radicand bits per step
        if (r_state == ST_MS_GO && r_count == '0) begin
            r_x   <= '0;
            r_res <= '0;
            r_bit <= 32'h4000_0000;
        end else if (r_state == ST_MS_WAIT && div_done) begin
            r_x   <= div_quo[31:0];
            r_res <= '0;
            r_bit <= 32'h4000_0000;
        end else if (r_state == ST_SQRT && r_bit != '0) begin
            if (r_x >= rb_sum) begin
                r_x   <= r_x - rb_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == ST_SC_GO && r_full == '0) begin
            r_scaled <= (r_smooth != '0) ? 16'hFFFF : 16'h0000;
        end else if (r_state == ST_SC_WAIT && div_done) begin
            r_scaled <= (|div_quo[SUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
        end
        if (r_state == ST_DONE && out_free) begin
            r_out.rms_level      <= r_res[15:0];
            r_out.smoothed_level <= r_smooth[SMOOTH_W-1:8];
            r_out.scaled_level   <= r_scaled;
            r_out.buffer_count   <= r_bufs + 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    `CHK_CLK(a_count_bound, i_clk, i_rst_n, r_count <= MAX_CNT,
        "frame count beyond buffer limit")
    `CHK_CLK(a_clear_on_result, i_clk, i_rst_n,
        (r_state == ST_DONE && out_free) |=> (r_count == '0 && r_sum == '0 && r_out_valid),
        "buffer not cleared when result loaded")
    `CHK_CLK(a_rms_range, i_clk, i_rst_n,
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:0] <= 16'd32768),
        "rms level out of range")
    `CHK_CLK(a_bufs_step, i_clk, i_rst_n,
        (r_bufs != $past(r_bufs)) |-> (r_bufs == $past(r_bufs) + 32'd1),
        "buffer count jumped")

endmodule

`default_nettype wire

// ----- tb/sv/tb_stereo_rms_level_meter_top.sv -----
// self-checking testbench for stereo_rms_level_meter_top: predicts buffer levels per frame beat
// and compares every result beat; depends on srlm_pkg and the top-level rtl only

module tb_stereo_rms_level_meter_top;
    import srlm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAMES  = 256;
    localparam int SETTLE_PAD  = 160;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tlast = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    stereo_rms_level_meter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // predictor state
    logic [15:0]     gain_reg = GAIN_RESET;
    logic [15:0]     full_scale_reg = FULL_SCALE_RESET;
    longint unsigned square_acc = 0;
    int unsigned     frames_in_buf = 0;
    longint unsigned smooth_acc = 0;
    logic [31:0]     buffers_closed = '0;
    t_result         pending_levels[$];

    int  mismatch_cnt = 0;
    int  idle_cycles = 0;
    int  rx_hold = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_gaps = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned sample_magnitude(input logic [15:0] s);
        longint unsigned u;
        u = s;
        return s[15] ? (64'd65536 - u) : u;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r, t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    task automatic absorb_frame(input logic [15:0] l, input logic [15:0] r, input logic last);
        longint unsigned ml, mr, mean, rms, g, sm, sc;
        t_result res;
        if (frames_in_buf < MAX_FRAMES) begin
            ml = sample_magnitude(l);
            mr = sample_magnitude(r);
            square_acc = square_acc + ml * ml + mr * mr;
            frames_in_buf++;
        end
        if (last) begin
            mean = (frames_in_buf == 0) ? 64'd0 : square_acc / (64'd2 * frames_in_buf);
            rms = floor_root(mean);
            g = gain_reg;
            sm = (smooth_acc * (64'd65536 - g) + (rms << 8) * g) >> 16;
            smooth_acc = sm & 64'hFF_FFFF;
            if (full_scale_reg == 16'd0) begin
                sc = (smooth_acc != 0) ? 64'd65535 : 64'd0;
            end else begin
                sc = (smooth_acc * 64'd256) / full_scale_reg;
                if (sc > 64'd65535) sc = 64'd65535;
            end
            buffers_closed = buffers_closed + 32'd1;
            square_acc = 0;
            frames_in_buf = 0;
            res.rms_level = rms[15:0];
            res.smoothed_level = smooth_acc[23:8];
            res.scaled_level = sc[15:0];
            res.buffer_count = buffers_closed;
            pending_levels.insert(pending_levels.size(), res);
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // frame beats feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            absorb_frame(i_s_axis_tdata[15:0], i_s_axis_tdata[31:16], i_s_axis_tlast);
    end

    // result beats are checked against the oldest pending level
    always @(posedge i_clk) begin : level_check
        t_result got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (pending_levels.size() == 0) begin
                report_mismatch("result beat with none pending, buffer_count",
                                got.buffer_count, 0);
            end else begin
                want = pending_levels.pop_front();
                if (got.rms_level !== want.rms_level)
                    report_mismatch("rms_level", got.rms_level, want.rms_level);
                if (got.smoothed_level !== want.smoothed_level)
                    report_mismatch("smoothed_level", got.smoothed_level, want.smoothed_level);
                if (got.scaled_level !== want.scaled_level)
                    report_mismatch("scaled_level", got.scaled_level, want.scaled_level);
                if (got.buffer_count !== want.buffer_count)
                    report_mismatch("buffer_count", got.buffer_count, want.buffer_count);
            end
        end
    end

    // receiver: long hold-off, random stall bursts, or always ready
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_hold--;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout with %0d results pending", pending_levels.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_frame(input logic [15:0] l, input logic [15:0] r, input logic last);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, l};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 31)) ^ {16{$urandom_range(0, 1) == 1}};
            3: return 16'($urandom_range(0, 2047)) ^ {16{$urandom_range(0, 1) == 1}};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_buffer(input int n);
        for (int i = 0; i < n; i++)
            send_frame(pick_sample(), pick_sample(), i == n - 1);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    // frames that close no buffer may still be in work after the last result
    task automatic quiesce();
        drain_results();
        repeat (SETTLE_PAD) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SMOOTHING_GAIN) gain_reg = val;
        else if (idx == CFG_FULL_SCALE) full_scale_reg = val;
        @(posedge i_clk);
    endtask

    task automatic set_levels(input logic [15:0] gain, input logic [15:0] full_scale);
        quiesce();
        cfg_write(CFG_SMOOTHING_GAIN, gain);
        cfg_write(CFG_FULL_SCALE, full_scale);
    endtask

    task automatic test_reset_defaults();
        send_frame(16'h8000, 16'h8000, 1'b1);
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h0001, 16'hFFFF, 1'b1);
        send_frame(16'h0000, 16'h0000, 1'b1);
        send_frame(16'h5555, 16'hAAAA, 1'b0);
        send_frame(16'hAAAA, 16'h5555, 1'b0);
        send_frame(16'h00FF, 16'hFF00, 1'b1);
    endtask

    task automatic test_config_extremes();
        set_levels(16'hFFFF, 16'd1);
        send_frame(16'h8000, 16'h8000, 1'b1);
        send_frame(16'h7FFF, 16'h7FFF, 1'b1);
        // zero full scale: saturated while nonzero, then zero once the level decays
        set_levels(16'hFFFF, 16'd0);
        send_frame(16'h8000, 16'h7FFF, 1'b1);
        send_frame(16'h0000, 16'h0000, 1'b0);
        send_frame(16'h0000, 16'h0000, 1'b1);
        send_frame(16'h0000, 16'h0000, 1'b1);
        send_frame(16'h0000, 16'h0000, 1'b1);
        // zero gain keeps the old level
        set_levels(16'd0, 16'hFFFF);
        send_frame(16'h8000, 16'h8000, 1'b1);
        set_levels(16'd1, 16'h8000);
        send_frame(16'h8000, 16'h8000, 1'b1);
        send_frame(16'h1234, 16'hEDCB, 1'b1);
    endtask

    task automatic test_frame_overflow();
        set_levels(16'd30000, 16'd20000);
        // frames past the buffer limit are loud but must not count
        for (int i = 0; i < MAX_FRAMES + 2; i++) begin
            if (i < MAX_FRAMES)
                send_frame(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)), 1'b0);
            else
                send_frame(16'h8000, 16'h8000, i == MAX_FRAMES + 1);
        end
    endtask

    task automatic test_output_backpressure();
        tx_gaps = 1'b0;
        rx_hold = HOLD_CYCLES;
        for (int i = 0; i < 16; i++) send_buffer($urandom_range(1, 2));
        drain_results();
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_buffers();
        int sent;
        int n;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_levels(16'($urandom), 16'($urandom_range(1, 65535)));
                1: set_levels(16'd0, 16'hFFFF);
                2: set_levels(16'hFFFF, 16'd1);
                3: set_levels(16'($urandom), 16'($urandom_range(1, 2000)));
                default: begin
                    set_levels(GAIN_RESET, FULL_SCALE_RESET);
                    tx_gaps = 1'b0;
                    rx_gaps = 1'b0;
                end
            endcase
            sent = 0;
            while (sent < 60) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
                send_buffer(n);
                sent += n;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_config_extremes();
        test_frame_overflow();
        test_output_backpressure();
        test_random_buffers();
        drain_results();
        repeat (SETTLE_PAD) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
